### rtl/ipv4_route_table_first_match_assert.svh
// Assertion macros; clk and arst_n are taken from the enclosing module.
`ifndef IPV4_ROUTE_TABLE_FIRST_MATCH_ASSERT_SVH
`define IPV4_ROUTE_TABLE_FIRST_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

`define IPRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define IPRT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define IPRT_ASSERT(lbl, prop, msg)

`define IPRT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/iprt_pkg.sv
package iprt_pkg;

	localparam int ROUTES     = 8;
	localparam int INTERFACES = 16;
	localparam int IDX_W      = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int IF_TOP     = INTERFACES - 1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] network;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  ifc;
	} route_t;

	typedef struct packed {
		logic   en;
		logic   add;
		idx_t   idx;
		route_t route;
	} wr_cmd_t;

endpackage

### rtl/iprt_req_if.sv
interface iprt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] dest_address;
	logic [31:0] net_mask;
	logic [31:0] gateway_in;
	logic [3:0]  interface_in;

	modport source (
		output valid, operation, dest_address, net_mask, gateway_in, interface_in,
		input  ready
	);

	modport sink (
		input  valid, operation, dest_address, net_mask, gateway_in, interface_in,
		output ready
	);
endinterface

### rtl/iprt_rsp_if.sv
interface iprt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] gateway_out;
	logic [3:0]  interface_out;

	modport source (
		output valid, status, gateway_out, interface_out,
		input  ready
	);

	modport sink (
		input  valid, status, gateway_out, interface_out,
		output ready
	);
endinterface

### rtl/iprt_table.sv
module iprt_table
	import iprt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  idx_t    rd_idx,
	output logic    rd_valid,
	output route_t  rd_route,
	input  wr_cmd_t wr
);

	logic [ROUTES-1:0] valid_q;
	route_t            route_q [ROUTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.add;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.add) begin
			route_q[wr.idx] <= wr.route;
		end
	end

	assign rd_valid = valid_q[rd_idx];
	assign rd_route = route_q[rd_idx];

endmodule

### rtl/ipv4_route_table_first_match.sv
// IPv4 route table, first match in slot order over ROUTES slots. One request
// (add, delete, search) is taken at a time: a single comparator walks the
// slots one per cycle from slot 0 and stops at the first hit or the last
// slot; the done state then waits until the output register can take the
// result. The response sits in an output register, so the next request
// may be accepted while the previous response waits.
// The table comes out of reset empty.
`include "ipv4_route_table_first_match_assert.svh"

module ipv4_route_table_first_match
	import iprt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	iprt_req_if.sink   req,
	iprt_rsp_if.source rsp
);

	state_t      state_q, state_d;
	idx_t        idx_q, idx_d;

	op_t         op_q;
	logic [31:0] addr_q;
	logic [31:0] mask_q;
	logic [31:0] gw_q;
	logic [3:0]  ifc_q;

	status_t     res_status_q, res_status_d;
	logic [31:0] res_gw_q, res_gw_d;
	logic [3:0]  res_ifc_q, res_ifc_d;
	logic        res_load;

	logic        rsp_valid_q;
	status_t     rsp_status_q;
	logic [31:0] rsp_gw_q;
	logic [3:0]  rsp_ifc_q;
	logic        rsp_load;

	logic        rd_valid;
	route_t      rd_route;
	wr_cmd_t     wr;
	logic        hit;
	logic        last;
	logic [3:0]  ifc_lim;
	logic        accept;

	iprt_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.rd_valid (rd_valid),
		.rd_route (rd_route),
		.wr       (wr)
	);

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign last      = (idx_q == IDX_W'(ROUTES - 1));
	assign ifc_lim   = (int'(ifc_q) > IF_TOP) ? 4'(IF_TOP) : ifc_q;

	always_comb begin
		unique case (op_q)
			OP_ADD:    hit = !rd_valid;
			OP_DELETE: hit = rd_valid && (rd_route.network == (addr_q & mask_q)) &&
			                 (rd_route.mask == mask_q);
			OP_SEARCH: hit = rd_valid && (rd_route.network == (addr_q & rd_route.mask));
			default:   hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		idx_d              = idx_q;
		res_load           = 1'b0;
		res_status_d       = ST_NOT_FOUND;
		res_gw_d           = '0;
		res_ifc_d          = '0;
		rsp_load           = 1'b0;
		wr.en              = 1'b0;
		wr.add             = 1'b0;
		wr.idx             = idx_q;
		wr.route.network   = addr_q & mask_q;
		wr.route.mask      = mask_q;
		wr.route.gateway   = gw_q;
		wr.route.ifc       = ifc_lim;
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_load     = 1'b1;
					res_status_d = ST_OK;
					state_d      = S_DONE;
					if (op_q == OP_ADD) begin
						wr.en  = 1'b1;
						wr.add = 1'b1;
					end else if (op_q == OP_DELETE) begin
						wr.en = 1'b1;
					end else begin
						res_gw_d  = rd_route.gateway;
						res_ifc_d = rd_route.ifc;
					end
				end else if (last) begin
					res_load     = 1'b1;
					res_status_d = (op_q == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(req.operation);
			addr_q <= req.dest_address;
			mask_q <= req.net_mask;
			gw_q   <= req.gateway_in;
			ifc_q  <= req.interface_in;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_gw_q     <= res_gw_d;
			res_ifc_q    <= res_ifc_d;
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_gw_q     <= res_gw_q;
			rsp_ifc_q    <= res_ifc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.gateway_out   = rsp_gw_q;
	assign rsp.interface_out = rsp_ifc_q;

	`IPRT_ASSERT(a_accept_scan, accept |=> (state_q == S_SCAN), "accept did not start a scan")
	`IPRT_ASSERT_NEVER(a_wr_outside_scan, wr.en && (state_q != S_SCAN), "table write outside scan")
	`IPRT_ASSERT(a_fail_zero, (rsp.valid && (rsp.status != ST_OK)) |-> ((rsp.gateway_out == '0) && (rsp.interface_out == '0)), "failed response carries data")
	`IPRT_ASSERT(a_load_done, rsp_load |-> (state_q == S_DONE), "response loaded outside done")

endmodule
